@@ rtl/sof_crc8_crc16_frame_deframer_defines.svh @@
// Assertion macros for the frame deframer RTL.
// Include by bare file name; expects signals named clock and reset in scope.
`ifndef SOF_CRC8_CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define SOF_CRC8_CRC16_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SCFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define SCFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/scfd_pkg.sv @@
// Shared types, constants and CRC step functions for the frame deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package scfd_pkg;

   // Largest payload a frame may carry; larger length fields are clamped
   localparam int MAX_PAYLOAD = 128;

   // Configuration register indexes
   localparam logic [2:0] CSR_START_BYTE  = 3'd0;
   localparam logic [2:0] CSR_CRC8_POLY   = 3'd1;
   localparam logic [2:0] CSR_CRC8_SEED   = 3'd2;
   localparam logic [2:0] CSR_CRC16_POLY  = 3'd3;
   localparam logic [2:0] CSR_CRC16_SEED  = 3'd4;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Frame status codes
   localparam logic [1:0] STATUS_GOOD      = 2'd0;
   localparam logic [1:0] STATUS_HDR_CRC   = 2'd1;
   localparam logic [1:0] STATUS_FRAME_CRC = 2'd2;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_HEADER  = 3'd1,
      PH_CMD     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CRC_LO  = 3'd4,
      PH_CRC_HI  = 3'd5
   } phase_type;

   // Configuration register set
   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  crc8_poly;
      logic [7:0]  crc8_seed;
      logic [15:0] crc16_poly;
      logic [15:0] crc16_seed;
   } cfg_type;

   // One received byte held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } item_type;

   // Reflected bytewise CRC8 step
   function automatic logic [7:0] crc8_next(input logic [7:0] crc,
                                            input logic [7:0] data,
                                            input logic [7:0] poly);
      logic [7:0] c;
      int         k;
      c = crc ^ data;
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   // Reflected bytewise CRC16 step
   function automatic logic [15:0] crc16_next(input logic [15:0] crc,
                                              input logic [7:0]  data,
                                              input logic [15:0] poly);
      logic [15:0] c;
      int          k;
      c = {8'h00, crc[7:0] ^ data};
      for (k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return {8'h00, crc[15:8]} ^ c;
   endfunction

endpackage

`default_nettype wire

@@ rtl/scfd_csr.sv @@
// Configuration registers of the frame deframer.
// Depends on scfd_pkg for the register indexes and cfg_type.
`default_nettype none

module scfd_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata,
   output scfd_pkg::cfg_type     cfg
);

   scfd_pkg::cfg_type cfg_ff, cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            scfd_pkg::CSR_START_BYTE: cfg_in.start_byte = csr_wdata[7:0];
            scfd_pkg::CSR_CRC8_POLY:  cfg_in.crc8_poly  = csr_wdata[7:0];
            scfd_pkg::CSR_CRC8_SEED:  cfg_in.crc8_seed  = csr_wdata[7:0];
            scfd_pkg::CSR_CRC16_POLY: cfg_in.crc16_poly = csr_wdata;
            scfd_pkg::CSR_CRC16_SEED: cfg_in.crc16_seed = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte <= 8'hA5;
         cfg_ff.crc8_poly  <= 8'h8C;
         cfg_ff.crc8_seed  <= 8'hFF;
         cfg_ff.crc16_poly <= 16'h8408;
         cfg_ff.crc16_seed <= 16'hFFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/scfd_in_reg.sv @@
// Input register stage: captures one received byte per cycle unless stalled.
// Depends on scfd_pkg for item_type.
`default_nettype none

module scfd_in_reg (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          take,
   output scfd_pkg::item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // Hold the byte while the parser cannot take it
   assign req_stall = valid_ff && !take;
   assign item      = '{valid: valid_ff, rx_byte: byte_ff};

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

`default_nettype wire

@@ rtl/scfd_parser.sv @@
// Frame parser: phase machine, header/frame CRCs and the result register.
// Depends on scfd_pkg and the assertion macros header.
`default_nettype none
`include "sof_crc8_crc16_frame_deframer_defines.svh"

module scfd_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scfd_pkg::cfg_type  cfg,
   input  wire scfd_pkg::item_type item,
   output logic                   take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_kind,
   output logic [15:0]            rsp_command_code,
   output logic [7:0]             rsp_payload_byte,
   output logic [6:0]             rsp_byte_position,
   output logic [7:0]             rsp_frame_length,
   output logic [1:0]             rsp_frame_status
);

   scfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [7:0]  hcrc_ff, hcrc_in;
   logic [15:0] fcrc_ff, fcrc_in;
   logic [7:0]  low_ff, low_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [15:0] out_cmd_ff, out_cmd_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [6:0]  out_pos_ff, out_pos_in;
   logic [7:0]  out_len_ff, out_len_in;
   logic [1:0]  out_status_ff, out_status_in;

   logic        out_free;
   logic        fire;
   logic [7:0]  b;
   logic [15:0] raw_len;
   logic [7:0]  pos_inc;
   logic [7:0]  hcrc_step;
   logic [15:0] fcrc_step;

   // Result slot is free when empty or being taken this cycle
   assign out_free = !out_valid_ff || !rsp_stall;
   assign take     = out_free;
   assign fire     = item.valid && out_free;
   assign b        = item.rx_byte;
   assign raw_len  = {b, len_ff};
   assign pos_inc  = pos_ff + 8'd1;

   // CRC steps over the current byte
   assign hcrc_step = scfd_pkg::crc8_next(hcrc_ff, b, cfg.crc8_poly);
   assign fcrc_step = scfd_pkg::crc16_next(fcrc_ff, b, cfg.crc16_poly);

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_command_code  = out_cmd_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_frame_length  = out_len_ff;
   assign rsp_frame_status  = out_status_ff;

   // Next state and result
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      cmd_in        = cmd_ff;
      hcrc_in       = hcrc_ff;
      fcrc_in       = fcrc_ff;
      low_in        = low_ff;
      out_valid_in  = out_free ? 1'b0 : out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_cmd_in    = out_cmd_ff;
      out_byte_in   = out_byte_ff;
      out_pos_in    = out_pos_ff;
      out_len_in    = out_len_ff;
      out_status_in = out_status_ff;
      if (fire) begin
         case (phase_ff)
            scfd_pkg::PH_HUNT: begin
               if (b == cfg.start_byte) begin
                  hcrc_in  = scfd_pkg::crc8_next(cfg.crc8_seed, b, cfg.crc8_poly);
                  fcrc_in  = scfd_pkg::crc16_next(cfg.crc16_seed, b, cfg.crc16_poly);
                  cmd_in   = 16'h0000;
                  len_in   = 8'h00;
                  pos_in   = 8'h00;
                  phase_in = scfd_pkg::PH_HEADER;
               end
            end
            scfd_pkg::PH_HEADER: begin
               if (pos_ff < 8'd3) begin
                  hcrc_in = hcrc_step;
                  fcrc_in = fcrc_step;
                  if (pos_ff == 8'd0) begin
                     len_in = b;
                  end else if (pos_ff == 8'd1) begin
                     len_in = (raw_len > 16'(scfd_pkg::MAX_PAYLOAD)) ?
                              8'(scfd_pkg::MAX_PAYLOAD) : raw_len[7:0];
                  end
                  pos_in = pos_inc;
               end else if (b != hcrc_ff) begin
                  // header check failed: report and resume hunting
                  phase_in      = scfd_pkg::PH_HUNT;
                  pos_in        = 8'h00;
                  out_valid_in  = 1'b1;
                  out_kind_in   = scfd_pkg::KIND_END;
                  out_cmd_in    = 16'h0000;
                  out_byte_in   = 8'h00;
                  out_pos_in    = 7'h00;
                  out_len_in    = len_ff;
                  out_status_in = scfd_pkg::STATUS_HDR_CRC;
               end else begin
                  fcrc_in  = fcrc_step;
                  phase_in = scfd_pkg::PH_CMD;
                  pos_in   = 8'h00;
               end
            end
            scfd_pkg::PH_CMD: begin
               fcrc_in = fcrc_step;
               if (pos_ff == 8'd0) begin
                  cmd_in = {8'h00, b};
                  pos_in = 8'd1;
               end else begin
                  cmd_in   = {b, cmd_ff[7:0]};
                  pos_in   = 8'h00;
                  phase_in = (len_ff == 8'd0) ? scfd_pkg::PH_CRC_LO : scfd_pkg::PH_PAYLOAD;
               end
            end
            scfd_pkg::PH_PAYLOAD: begin
               fcrc_in       = fcrc_step;
               out_valid_in  = 1'b1;
               out_kind_in   = scfd_pkg::KIND_PAYLOAD;
               out_cmd_in    = cmd_ff;
               out_byte_in   = b;
               out_pos_in    = pos_ff[6:0];
               out_len_in    = len_ff;
               out_status_in = scfd_pkg::STATUS_GOOD;
               pos_in        = pos_inc;
               if (pos_inc >= len_ff) begin
                  pos_in   = 8'h00;
                  phase_in = scfd_pkg::PH_CRC_LO;
               end
            end
            scfd_pkg::PH_CRC_LO: begin
               low_in   = b;
               phase_in = scfd_pkg::PH_CRC_HI;
            end
            scfd_pkg::PH_CRC_HI: begin
               phase_in      = scfd_pkg::PH_HUNT;
               pos_in        = 8'h00;
               out_valid_in  = 1'b1;
               out_kind_in   = scfd_pkg::KIND_END;
               out_cmd_in    = cmd_ff;
               out_byte_in   = 8'h00;
               out_pos_in    = 7'h00;
               out_len_in    = len_ff;
               out_status_in = ({b, low_ff} == fcrc_ff) ?
                               scfd_pkg::STATUS_GOOD : scfd_pkg::STATUS_FRAME_CRC;
            end
            default: begin
               phase_in = scfd_pkg::PH_HUNT;
               pos_in   = 8'h00;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= scfd_pkg::PH_HUNT;
         pos_ff       <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame data and result payload
   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      cmd_ff        <= cmd_in;
      hcrc_ff       <= hcrc_in;
      fcrc_ff       <= fcrc_in;
      low_ff        <= low_in;
      out_kind_ff   <= out_kind_in;
      out_cmd_ff    <= out_cmd_in;
      out_byte_ff   <= out_byte_in;
      out_pos_ff    <= out_pos_in;
      out_len_ff    <= out_len_in;
      out_status_ff <= out_status_in;
   end

   `SCFD_ASSERT_NOW(a_payload_in_range, out_valid_ff && (out_kind_ff == scfd_pkg::KIND_PAYLOAD), ({1'b0, out_pos_ff} < out_len_ff) && (out_status_ff == scfd_pkg::STATUS_GOOD), "payload result outside frame length")
   `SCFD_ASSERT_NOW(a_end_fields_zero, out_valid_ff && (out_kind_ff == scfd_pkg::KIND_END), (out_byte_ff == 8'h00) && (out_pos_ff == 7'h00), "end report carries payload fields")
   `SCFD_ASSERT_NOW(a_hdr_fail_no_cmd, out_valid_ff && (out_status_ff == scfd_pkg::STATUS_HDR_CRC), out_cmd_ff == 16'h0000, "header failure reports a command")
   `SCFD_ASSERT_NEXT(a_result_held, out_valid_ff && rsp_stall, out_valid_ff && $stable(out_cmd_ff) && $stable(out_status_ff), "stalled result lost")
   `SCFD_ASSERT_NOW(a_len_clamped, phase_ff == scfd_pkg::PH_PAYLOAD, (len_ff <= 8'(scfd_pkg::MAX_PAYLOAD)) && (pos_ff < len_ff), "payload count beyond clamped length")

endmodule

`default_nettype wire

@@ rtl/sof_crc8_crc16_frame_deframer.sv @@
// Top level of the start-of-frame deframer with header CRC8 and frame CRC16.
// Depends on scfd_pkg, scfd_csr, scfd_in_reg and scfd_parser.
`default_nettype none

// Takes one received byte per clock cycle and sustains that rate while the result
// side does not stall: each byte passes an input register, one pass of the phase
// machine with its bytewise CRC8/CRC16 networks, and lands in the result register,
// from which its result is presented. A payload byte yields one result,
// the last frame CRC byte or a failed header check yields one end report, and
// other bytes yield none. When both registers hold an item, a stall on the result
// side reaches req_stall in the same cycle. There is no start-up clearing pass.
// Configuration writes are taken at any time but are meant for an idle block;
// CRC seeds are loaded at each start byte.
module sof_crc8_crc16_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [15:0]      rsp_command_code,
   output logic [7:0]       rsp_payload_byte,
   output logic [6:0]       rsp_byte_position,
   output logic [7:0]       rsp_frame_length,
   output logic [1:0]       rsp_frame_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   scfd_pkg::cfg_type  cfg;
   scfd_pkg::item_type item;
   logic               take;

   // Configuration registers
   scfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input byte register
   scfd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .item        (item)
   );

   // Phase machine and result register
   scfd_parser u_parser (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .item              (item),
      .take              (take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_command_code  (rsp_command_code),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_status  (rsp_frame_status)
   );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking bench for the start-of-frame deframer: frames, noise and broken
// frames in, payload items and end-of-frame reports checked against a predictor.
// Depends on scfd_pkg and sof_crc8_crc16_frame_deframer.
`default_nettype none

module tb_top;

   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 40;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   // One predicted result item
   typedef struct {
      logic        kind;
      logic [15:0] cmd;
      logic [7:0]  pbyte;
      logic [6:0]  pos;
      logic [7:0]  len;
      logic [1:0]  status;
   } deframe_item_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_command_code;
   logic [7:0]  rsp_payload_byte;
   logic [6:0]  rsp_byte_position;
   logic [7:0]  rsp_frame_length;
   logic [1:0]  rsp_frame_status;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'h0000;

   // Register mirror, at reset values
   logic [7:0]  cfg_start      = 8'hA5;
   logic [7:0]  cfg_crc8_poly  = 8'h8C;
   logic [7:0]  cfg_crc8_seed  = 8'hFF;
   logic [15:0] cfg_crc16_poly = 16'h8408;
   logic [15:0] cfg_crc16_seed = 16'hFFFF;

   // Parser state of the predictor
   scfd_pkg::phase_type parse_phase = scfd_pkg::PH_HUNT;
   int unsigned parse_count = 0;
   logic [7:0]  clamp_len   = 8'h00;
   logic [15:0] cmd_word    = 16'h0000;
   logic [7:0]  hdr_crc     = 8'hFF;
   logic [15:0] frm_crc     = 16'hFFFF;
   logic [7:0]  fcs_low     = 8'h00;

   logic [7:0]       rx_byte_q[$];
   deframe_item_type deframe_q[$];

   int  stim_count  = 0;
   int  error_count = 0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   int  hold_left   = 0;
   int  quiet_count = 0;
   bit  req_burst   = 1'b0;
   bit  rsp_burst   = 1'b0;
   bit  pressure_arm = 1'b0;
   deframe_item_type want;

   sof_crc8_crc16_frame_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_command_code  (rsp_command_code),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_status  (rsp_frame_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Reflected CRC8 over one byte, current polynomial
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      r = acc ^ d;
      repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? cfg_crc8_poly : 8'h00);
      return r;
   endfunction

   // Reflected CRC16 over one byte, current polynomial
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = {8'h00, acc[7:0] ^ d};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? cfg_crc16_poly : 16'h0000);
      return r ^ {8'h00, acc[15:8]};
   endfunction

   // Advance the parser by one accepted byte and queue what it yields
   function automatic void predict_deframe(input logic [7:0] b);
      logic [15:0]      raw;
      deframe_item_type r;
      case (parse_phase)
         scfd_pkg::PH_HUNT: begin
            if (b == cfg_start) begin
               hdr_crc     = crc8_step(cfg_crc8_seed, b);
               frm_crc     = crc16_step(cfg_crc16_seed, b);
               cmd_word    = 16'h0000;
               clamp_len   = 8'h00;
               parse_count = 0;
               parse_phase = scfd_pkg::PH_HEADER;
            end
         end
         scfd_pkg::PH_HEADER: begin
            if (parse_count < 3) begin
               hdr_crc = crc8_step(hdr_crc, b);
               frm_crc = crc16_step(frm_crc, b);
               if (parse_count == 0) begin
                  clamp_len = b;
               end else if (parse_count == 1) begin
                  raw = {b, clamp_len};
                  clamp_len = (raw > 16'(scfd_pkg::MAX_PAYLOAD)) ?
                              8'(scfd_pkg::MAX_PAYLOAD) : raw[7:0];
               end
               parse_count++;
            end else if (b != hdr_crc) begin
               // header check failed: report and resume hunting
               r = '{scfd_pkg::KIND_END, 16'h0000, 8'h00, 7'd0, clamp_len,
                     scfd_pkg::STATUS_HDR_CRC};
               deframe_q.push_back(r);
               parse_phase = scfd_pkg::PH_HUNT;
               parse_count = 0;
            end else begin
               frm_crc     = crc16_step(frm_crc, b);
               parse_phase = scfd_pkg::PH_CMD;
               parse_count = 0;
            end
         end
         scfd_pkg::PH_CMD: begin
            frm_crc = crc16_step(frm_crc, b);
            if (parse_count == 0) begin
               cmd_word    = {8'h00, b};
               parse_count = 1;
            end else begin
               cmd_word[15:8] = b;
               parse_count    = 0;
               parse_phase    = (clamp_len == 8'h00) ? scfd_pkg::PH_CRC_LO :
                                                       scfd_pkg::PH_PAYLOAD;
            end
         end
         scfd_pkg::PH_PAYLOAD: begin
            frm_crc = crc16_step(frm_crc, b);
            r = '{scfd_pkg::KIND_PAYLOAD, cmd_word, b, parse_count[6:0], clamp_len,
                  scfd_pkg::STATUS_GOOD};
            deframe_q.push_back(r);
            parse_count++;
            if (parse_count >= 32'(clamp_len)) begin
               parse_count = 0;
               parse_phase = scfd_pkg::PH_CRC_LO;
            end
         end
         scfd_pkg::PH_CRC_LO: begin
            fcs_low     = b;
            parse_phase = scfd_pkg::PH_CRC_HI;
         end
         scfd_pkg::PH_CRC_HI: begin
            r = '{scfd_pkg::KIND_END, cmd_word, 8'h00, 7'd0, clamp_len,
                  ({b, fcs_low} == frm_crc) ? scfd_pkg::STATUS_GOOD :
                                              scfd_pkg::STATUS_FRAME_CRC};
            deframe_q.push_back(r);
            parse_phase = scfd_pkg::PH_HUNT;
            parse_count = 0;
         end
         default: begin
            parse_phase = scfd_pkg::PH_HUNT;
            parse_count = 0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] exp_val);
      if (error_count < PRINT_LIMIT)
         $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
      error_count++;
   endtask

   // Driver: predicts on acceptance, then waits its drawn gap before the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_deframe(req_rx_byte);
            gap_left = req_burst ? 0 : $urandom_range(0, 7);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_byte_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result item and draws its own stall per item
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (deframe_q.size() == 0) begin
               report_mismatch("unexpected item kind", 16'(rsp_kind), 16'h0000);
            end else begin
               want = deframe_q.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 16'(rsp_kind), 16'(want.kind));
               if (rsp_command_code !== want.cmd)
                  report_mismatch("command_code", rsp_command_code, want.cmd);
               if (rsp_payload_byte !== want.pbyte)
                  report_mismatch("payload_byte", 16'(rsp_payload_byte), 16'(want.pbyte));
               if (rsp_byte_position !== want.pos)
                  report_mismatch("byte_position", 16'(rsp_byte_position), 16'(want.pos));
               if (rsp_frame_length !== want.len)
                  report_mismatch("frame_length", 16'(rsp_frame_length), 16'(want.len));
               if (rsp_frame_status !== want.status)
                  report_mismatch("frame_status", 16'(rsp_frame_status), 16'(want.status));
            end
            stall_left = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         // long hold-off so the block backs up into req_stall
         if (pressure_arm) begin
            pressure_arm = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
         if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("timeout: no traffic for %0d cycles", WATCHDOG_LIMIT);
            $display("sof_crc8_crc16_frame_deframer test failed");
            $finish;
         end
      end
   end

   function automatic void push_byte(input logic [7:0] b);
      rx_byte_q.push_back(b);
      stim_count++;
   endfunction

   // Random byte that cannot open a frame
   function automatic logic [7:0] quiet_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == cfg_start) ? ~b : b;
   endfunction

   // Frame under the current settings, optionally with a bad header or frame check; fill < 0 means random payload
   function automatic void queue_frame(input logic [15:0] len_field, input logic [15:0] cmd,
                                       input int fill, input bit bad_hdr, input bit bad_fcs);
      logic [7:0]  hb [4];
      logic [7:0]  hc;
      logic [7:0]  pb;
      logic [7:0]  flip8;
      logic [15:0] flip16;
      logic [15:0] fc;
      int          n;
      int          k;
      hb[0] = cfg_start;
      hb[1] = len_field[7:0];
      hb[2] = len_field[15:8];
      hb[3] = 8'($urandom_range(0, 255));
      hc = cfg_crc8_seed;
      fc = cfg_crc16_seed;
      for (k = 0; k < 4; k++) begin
         hc = crc8_step(hc, hb[k]);
         fc = crc16_step(fc, hb[k]);
         push_byte(hb[k]);
      end
      if (bad_hdr) begin
         flip8 = 8'($urandom_range(1, 255));
         push_byte(hc ^ flip8);
         return;
      end
      push_byte(hc);
      fc = crc16_step(fc, hc);
      push_byte(cmd[7:0]);
      fc = crc16_step(fc, cmd[7:0]);
      push_byte(cmd[15:8]);
      fc = crc16_step(fc, cmd[15:8]);
      n = (len_field > 16'(scfd_pkg::MAX_PAYLOAD)) ? scfd_pkg::MAX_PAYLOAD :
                                                     int'(len_field);
      for (k = 0; k < n; k++) begin
         pb = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         push_byte(pb);
         fc = crc16_step(fc, pb);
      end
      if (bad_fcs) begin
         flip16 = 16'($urandom_range(1, 65535));
         fc = fc ^ flip16;
      end
      push_byte(fc[7:0]);
      push_byte(fc[15:8]);
   endfunction

   // One random unit: mostly frames, some noise and broken frames
   function automatic void queue_random_unit();
      int          r;
      int          k;
      logic [15:0] lf;
      r = $urandom_range(0, 99);
      if (r < 72) begin
         k = $urandom_range(0, 99);
         if (k < 80) begin
            lf = 16'($urandom_range(0, 8));
         end else if (k < 99) begin
            lf = 16'($urandom_range(9, 40));
         end else begin
            case ($urandom_range(0, 3))
               0:       lf = 16'(scfd_pkg::MAX_PAYLOAD);
               1:       lf = 16'(scfd_pkg::MAX_PAYLOAD + 1);
               2:       lf = 16'hFFFF;
               default: lf = 16'($urandom_range(130, 65534));
            endcase
         end
         queue_frame(lf, 16'($urandom_range(0, 65535)), -1,
                     $urandom_range(0, 9) == 0, $urandom_range(0, 6) == 0);
         if ($urandom_range(0, 2) == 0)
            push_byte(quiet_byte());
      end else if (r < 82) begin
         repeat ($urandom_range(1, 4)) push_byte(quiet_byte());
      end else if (r < 91) begin
         // truncated frame that swallows whatever follows
         push_byte(cfg_start);
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // Wait until everything sent has been taken and answered, then let the pipe settle
   task automatic drain();
      do @(negedge clock);
      while (rx_byte_q.size() != 0 || req_valid || deframe_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         scfd_pkg::CSR_START_BYTE: cfg_start      = value[7:0];
         scfd_pkg::CSR_CRC8_POLY:  cfg_crc8_poly  = value[7:0];
         scfd_pkg::CSR_CRC8_SEED:  cfg_crc8_seed  = value[7:0];
         scfd_pkg::CSR_CRC16_POLY: cfg_crc16_poly = value;
         scfd_pkg::CSR_CRC16_SEED: cfg_crc16_seed = value;
         default: ;
      endcase
   endtask

   // Write the whole register set; upper bits of the byte registers are junk
   task automatic configure(input logic [7:0] sb, input logic [7:0] p8, input logic [7:0] s8,
                            input logic [15:0] p16, input logic [15:0] s16);
      logic [7:0] junk;
      junk = 8'($urandom_range(0, 255));
      write_reg(scfd_pkg::CSR_START_BYTE, {junk, sb});
      write_reg(scfd_pkg::CSR_CRC8_POLY, {~junk, p8});
      write_reg(scfd_pkg::CSR_CRC8_SEED, {junk, s8});
      write_reg(scfd_pkg::CSR_CRC16_POLY, p16);
      write_reg(scfd_pkg::CSR_CRC16_SEED, s16);
      @(negedge clock);
   endtask

   task automatic run_random(input int n_items, input bit s_burst, input bit r_burst,
                             input bit press);
      int target;
      @(negedge clock);
      req_burst = s_burst;
      rsp_burst = r_burst;
      target = stim_count + n_items;
      while (stim_count < target) queue_random_unit();
      if (press) pressure_arm = 1'b1;
      drain();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: idle bytes, header failure with oversized length, empty frame,
      // one-byte frame with a bad frame check
      push_byte(8'h00);
      push_byte(8'hFF);
      queue_frame(16'hFFFF, 16'h1234, -1, 1'b1, 1'b0);
      queue_frame(16'h0000, 16'hFFFF, -1, 1'b0, 1'b0);
      queue_frame(16'h0001, 16'h0000, 255, 1'b0, 1'b1);
      drain();
      run_random(300, 1'b0, 1'b0, 1'b0);

      // all-zero settings
      configure(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
      run_random(340, 1'b0, 1'b0, 1'b0);

      // all-ones settings, sender flat out against a long receiver hold-off
      configure(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      run_random(340, 1'b1, 1'b0, 1'b1);

      // random settings
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
      run_random(340, 1'b0, 1'b1, 1'b0);

      // back to power-up values, plus a write to an unused index
      configure(8'hA5, 8'h8C, 8'hFF, 16'h8408, 16'hFFFF);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      @(negedge clock);
      run_random(340, 1'b1, 1'b1, 1'b0);

      if (error_count == 0)
         $display("sof_crc8_crc16_frame_deframer test passed");
      else
         $display("sof_crc8_crc16_frame_deframer test failed");
      $finish;
   end

endmodule

`default_nettype wire
